// ===== sv/hrhp_pkg.sv =====
package hrhp_pkg;

    localparam logic [2:0] KIND_METHOD = 3'd0;
    localparam logic [2:0] KIND_URI    = 3'd1;
    localparam logic [2:0] KIND_KEY    = 3'd2;
    localparam logic [2:0] KIND_VALUE  = 3'd3;
    localparam logic [2:0] KIND_STATUS = 3'd4;

    localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
    localparam logic [1:0] STATUS_NO_BODY    = 2'd1;
    localparam logic [1:0] STATUS_WITH_BODY  = 2'd2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] NAME_LEN = 4'd14;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [3:0]  header_number;
        logic [31:0] content_length;
        logic [1:0]  parse_status;
        logic        final_result;
    } result_t;

    // "Content-Length"
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:  c = 8'h43;
            4'd1:  c = 8'h6f;
            4'd2:  c = 8'h6e;
            4'd3:  c = 8'h74;
            4'd4:  c = 8'h65;
            4'd5:  c = 8'h6e;
            4'd6:  c = 8'h74;
            4'd7:  c = 8'h2d;
            4'd8:  c = 8'h4c;
            4'd9:  c = 8'h65;
            4'd10: c = 8'h6e;
            4'd11: c = 8'h67;
            4'd12: c = 8'h74;
            4'd13: c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/http_request_header_parser.sv =====
// HTTP/1.1 request header parser. Takes one request byte per transaction, with
// s_last_byte on the final byte of a message, and reports the method, the URI,
// each header key and value (up to MAX_HEADER_COUNT headers) as each token
// closes, then a final status transaction on the last byte carrying the decoded
// Content-Length, the parse status and the body span. A byte is registered on
// input and parsed from that register, waiting while the queue is too full; its
// results enter a four-entry result queue, which offers them on m_valid. One byte
// is accepted every cycle while the queue holds at most two results; with m_ready
// held high that sustains one byte per cycle, a byte that both closes a token
// and ends the message pushing two results. Offsets wrap modulo 2^OFFSET_BITS
// and are reported in 16 bits.
module http_request_header_parser #(
    parameter int MAX_HEADER_COUNT = 16,
    parameter int OFFSET_BITS      = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_token_kind,
    output logic [15:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic [3:0]  m_header_number,
    output logic [31:0] m_content_length,
    output logic [1:0]  m_parse_status,
    output logic        m_final_result
);

    localparam int OB      = OFFSET_BITS;
    localparam int HC_BITS = $clog2(MAX_HEADER_COUNT + 1);

    typedef enum logic [2:0] {
        PH_METHOD, PH_URI, PH_VERSION, PH_LINE, PH_LINE_CR, PH_KEY, PH_VALUE, PH_BODY
    } phase_t;

    function automatic logic [15:0] to16(input logic [OB-1:0] x);
        logic [OB+15:0] e;
        e = {16'b0, x};
        return e[15:0];
    endfunction

    function automatic logic [31:0] to32(input logic [OB-1:0] x);
        logic [OB+31:0] e;
        e = {32'b0, x};
        return e[31:0];
    endfunction

    function automatic logic [3:0] hnum4(input logic [HC_BITS-1:0] x);
        logic [HC_BITS+3:0] e;
        e = {4'b0, x};
        return e[3:0];
    endfunction

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // parser state
    phase_t              phase_reg, phase_next;
    logic [OB-1:0]       pos_reg, pos_next;
    logic [OB-1:0]       begin_reg, begin_next;
    logic                delim_reg, delim_next;
    logic [HC_BITS-1:0]  hcount_reg, hcount_next;
    logic [3:0]          nmp_reg, nmp_next;
    logic                nsm_reg, nsm_next;
    logic [31:0]         acc_reg, acc_next;
    logic                seen_reg, seen_next;
    logic [OB-1:0]       hend_reg, hend_next;

    // result queue
    hrhp_pkg::result_t q_reg [4];
    logic [1:0] rd_ptr_reg, wr_ptr_reg;
    logic [2:0] count_reg;

    logic advance, pop;
    logic tok_valid, fin_valid;
    hrhp_pkg::result_t tok_res, fin_res;

    assign advance = in_valid_reg && (count_reg <= 3'd2);
    assign s_ready = !in_valid_reg || advance;
    assign pop     = m_valid && m_ready;

    always_comb begin
        logic [7:0]    b;
        logic [OB-1:0] p;
        logic          do_key;
        logic          key_done;
        logic          in_limit;
        logic          hit;
        logic [35:0]   v;
        logic [31:0]   cl;
        logic [OB-1:0] got;

        b = in_data_reg;
        p = pos_reg;
        do_key = 1'b0;
        key_done = 1'b0;
        in_limit = 1'b0;
        hit = 1'b0;
        v = '0;
        cl = '0;
        got = '0;

        phase_next  = phase_reg;
        begin_next  = begin_reg;
        delim_next  = delim_reg;
        hcount_next = hcount_reg;
        nmp_next    = nmp_reg;
        nsm_next    = nsm_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        hend_next   = hend_reg;

        tok_valid = 1'b0;
        tok_res   = '0;
        fin_valid = 1'b0;
        fin_res   = '0;

        case (phase_reg)
            PH_METHOD, PH_URI: begin
                if (b == hrhp_pkg::CHAR_SPACE) begin
                    tok_valid = 1'b1;
                    tok_res.token_kind = (phase_reg == PH_METHOD) ?
                        hrhp_pkg::KIND_METHOD : hrhp_pkg::KIND_URI;
                    tok_res.token_start  = to16(begin_reg);
                    tok_res.token_length = to16(p - begin_reg);
                    phase_next = (phase_reg == PH_METHOD) ? PH_URI : PH_VERSION;
                    begin_next = p + OB'(1);
                end
            end
            PH_VERSION: begin
                if (delim_reg && b == hrhp_pkg::CHAR_LF) begin
                    delim_next = 1'b0;
                    phase_next = PH_LINE;
                    begin_next = p + OB'(1);
                end else begin
                    delim_next = (b == hrhp_pkg::CHAR_CR);
                end
            end
            PH_LINE: begin
                begin_next = p;
                nmp_next   = '0;
                nsm_next   = 1'b1;
                delim_next = 1'b0;
                if (b == hrhp_pkg::CHAR_CR) begin
                    phase_next = PH_LINE_CR;
                end else begin
                    phase_next = PH_KEY;
                    do_key = 1'b1;
                end
            end
            PH_LINE_CR: begin
                if (b == hrhp_pkg::CHAR_LF) begin
                    hend_next  = p + OB'(1);
                    phase_next = PH_BODY;
                end else begin
                    nsm_next   = 1'b0;
                    phase_next = PH_KEY;
                    do_key = 1'b1;
                end
            end
            PH_KEY: begin
                do_key = 1'b1;
            end
            PH_VALUE: begin
                if (delim_reg && b == hrhp_pkg::CHAR_LF) begin
                    if (hcount_reg < HC_BITS'(MAX_HEADER_COUNT)) begin
                        tok_valid = 1'b1;
                        tok_res.token_kind    = hrhp_pkg::KIND_VALUE;
                        tok_res.token_start   = to16(begin_reg);
                        tok_res.token_length  = to16(p - OB'(1) - begin_reg);
                        tok_res.header_number = hnum4(hcount_reg);
                        hcount_next = hcount_reg + HC_BITS'(1);
                    end
                    delim_next = 1'b0;
                    phase_next = PH_LINE;
                    begin_next = p + OB'(1);
                end else begin
                    delim_next = (b == hrhp_pkg::CHAR_CR);
                    if (nsm_reg) begin
                        if (b >= hrhp_pkg::CHAR_ZERO && b <= hrhp_pkg::CHAR_NINE) begin
                            v = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                                + {32'b0, b[3:0]};
                            acc_next = (v[35:32] != 4'b0) ? 32'hffff_ffff : v[31:0];
                        end else begin
                            nsm_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // header key byte, working on the values set up above
        if (do_key) begin
            if (delim_next) begin
                if (b == hrhp_pkg::CHAR_SPACE) begin
                    in_limit = hcount_next < HC_BITS'(MAX_HEADER_COUNT);
                    hit = nsm_next && (nmp_next == hrhp_pkg::NAME_LEN);
                    if (in_limit) begin
                        tok_valid = 1'b1;
                        tok_res.token_kind    = hrhp_pkg::KIND_KEY;
                        tok_res.token_start   = to16(begin_next);
                        tok_res.token_length  = to16(p - OB'(1) - begin_next);
                        tok_res.header_number = hnum4(hcount_next);
                    end
                    if (in_limit && hit && !seen_next) begin
                        seen_next = 1'b1;
                        acc_next  = '0;
                        nsm_next  = 1'b1;
                    end else begin
                        nsm_next = 1'b0;
                    end
                    delim_next = 1'b0;
                    begin_next = p + OB'(1);
                    phase_next = PH_VALUE;
                    key_done = 1'b1;
                end else begin
                    if (nsm_next && nmp_next < hrhp_pkg::NAME_LEN &&
                        hrhp_pkg::CHAR_COLON == hrhp_pkg::name_char(nmp_next)) begin
                        nmp_next = nmp_next + 4'd1;
                    end else begin
                        nsm_next = 1'b0;
                    end
                    delim_next = 1'b0;
                end
            end
            if (!key_done) begin
                if (b == hrhp_pkg::CHAR_COLON) begin
                    delim_next = 1'b1;
                end else if (nsm_next && nmp_next < hrhp_pkg::NAME_LEN &&
                             b == hrhp_pkg::name_char(nmp_next)) begin
                    nmp_next = nmp_next + 4'd1;
                end else begin
                    nsm_next = 1'b0;
                end
            end
        end

        pos_next = p + OB'(1);

        if (in_last_reg) begin
            fin_valid = 1'b1;
            cl = seen_next ? acc_next : 32'd0;
            got = pos_next - hend_next;
            fin_res.token_kind     = hrhp_pkg::KIND_STATUS;
            fin_res.content_length = cl;
            fin_res.final_result   = 1'b1;
            fin_res.parse_status   = hrhp_pkg::STATUS_INCOMPLETE;
            if (phase_next == PH_BODY) begin
                if (cl == 32'd0) begin
                    fin_res.parse_status = hrhp_pkg::STATUS_NO_BODY;
                    fin_res.token_start  = to16(hend_next);
                end else if (to32(got) >= cl) begin
                    fin_res.parse_status = hrhp_pkg::STATUS_WITH_BODY;
                    fin_res.token_start  = to16(hend_next);
                    fin_res.token_length = to16(got);
                end
            end
            phase_next  = PH_METHOD;
            pos_next    = '0;
            begin_next  = '0;
            delim_next  = 1'b0;
            hcount_next = '0;
            nmp_next    = '0;
            nsm_next    = 1'b1;
            acc_next    = '0;
            seen_next   = 1'b0;
            hend_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_METHOD;
            pos_reg      <= '0;
            begin_reg    <= '0;
            delim_reg    <= 1'b0;
            hcount_reg   <= '0;
            nmp_reg      <= '0;
            nsm_reg      <= 1'b1;
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
            hend_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                begin_reg  <= begin_next;
                delim_reg  <= delim_next;
                hcount_reg <= hcount_next;
                nmp_reg    <= nmp_next;
                nsm_reg    <= nsm_next;
                acc_reg    <= acc_next;
                seen_reg   <= seen_next;
                hend_reg   <= hend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // result queue
    logic [1:0] push_cnt;
    assign push_cnt = advance ? ({1'b0, tok_valid} + {1'b0, fin_valid}) : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            count_reg  <= count_reg + {1'b0, push_cnt} - {2'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= tok_valid ? tok_res : fin_res;
        end
        if (push_cnt == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= fin_res;
        end
    end

    assign m_valid          = (count_reg != 3'd0);
    assign m_token_kind     = q_reg[rd_ptr_reg].token_kind;
    assign m_token_start    = q_reg[rd_ptr_reg].token_start;
    assign m_token_length   = q_reg[rd_ptr_reg].token_length;
    assign m_header_number  = q_reg[rd_ptr_reg].header_number;
    assign m_content_length = q_reg[rd_ptr_reg].content_length;
    assign m_parse_status   = q_reg[rd_ptr_reg].parse_status;
    assign m_final_result   = q_reg[rd_ptr_reg].final_result;

endmodule
